// File: rtl/core/rfe_pkg.sv
package rfe_pkg;

    // Field widths of the snapshot and result transactions.
    localparam int unsigned RAW_W     = 8;
    localparam int unsigned EPOCH_W   = 32;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned CFG_DAT_W = 1;

    // Internal widths. The full year is at most 255 * 100 + 255.
    localparam int unsigned YEAR_W   = 15;
    localparam int unsigned Q_W      = 9;   // full year / 100, at most 257
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned BEFORE_W = 9;   // days before a month, at most 335
    localparam int unsigned TOD_W    = 20;  // hour * 3600 + minute * 60 + second
    localparam int unsigned DAYS_W   = 25;  // signed day difference to the epoch

    // Reciprocal of 100 for full years below 2**15: floor(y * 5243 / 2**19).
    localparam int unsigned RECIP_100   = 5243;
    localparam int unsigned RECIP_SHIFT = 19;
    localparam int unsigned RECIP_W     = 13;

    localparam int unsigned EPOCH_YEAR = 1970;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BCD_MODE     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HOUR_24_MODE = CFG_IDX_W'(1);

    localparam int unsigned   HOUR_PM_BIT = 7;
    localparam logic [RAW_W-1:0] HOUR_MASK = 8'h7F;
    localparam logic [RAW_W-1:0] NOON_HOUR = 8'd12;

    // Days from 1 January of year 1 to 1 January of year y, for y >= 1.
    function automatic int unsigned year_start_days(input int unsigned y);
        int unsigned p;
        p = y - 1;
        return 365 * p + p / 4 - p / 100 + p / 400;
    endfunction

    // Packed BCD to binary when bcd is set, else the byte unchanged; nibbles above nine keep their binary weight.
    function automatic logic [RAW_W-1:0] decode_byte(input logic [RAW_W-1:0] b,
                                                     input logic bcd);
        logic [RAW_W-1:0] hi;
        logic [RAW_W-1:0] lo;
        hi = {4'd0, b[7:4]};
        lo = {4'd0, b[3:0]};
        return bcd ? RAW_W'(hi * 8'd10 + lo) : b;
    endfunction

    // Days in the year before the first of a month, without the leap day.
    function automatic logic [BEFORE_W-1:0] cum_days(input logic [MONTH_W-1:0] m);
        logic [BEFORE_W-1:0] d;
        unique case (m)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// File: rtl/core/rfe_in_if.sv
interface rfe_in_if;
    logic                            valid;
    logic                            ready;
    logic [rfe_pkg::RAW_W-1:0]       century_raw;
    logic [rfe_pkg::RAW_W-1:0]       year_raw;
    logic [rfe_pkg::RAW_W-1:0]       month_raw;
    logic [rfe_pkg::RAW_W-1:0]       day_raw;
    logic [rfe_pkg::RAW_W-1:0]       hour_raw;
    logic [rfe_pkg::RAW_W-1:0]       minute_raw;
    logic [rfe_pkg::RAW_W-1:0]       second_raw;

    modport source (
        output valid, century_raw, year_raw, month_raw, day_raw,
               hour_raw, minute_raw, second_raw,
        input  ready
    );
    modport sink (
        input  valid, century_raw, year_raw, month_raw, day_raw,
               hour_raw, minute_raw, second_raw,
        output ready
    );
endinterface

// File: rtl/core/rfe_out_if.sv
interface rfe_out_if;
    logic                            valid;
    logic                            ready;
    logic [rfe_pkg::EPOCH_W-1:0]     epoch_seconds;
    logic                            invalid;

    modport source (output valid, epoch_seconds, invalid, input ready);
    modport sink   (input valid, epoch_seconds, invalid, output ready);
endinterface

// File: rtl/core/rfe_cfg_if.sv
interface rfe_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [rfe_pkg::CFG_IDX_W-1:0]   reg_index;
    logic [rfe_pkg::CFG_DAT_W-1:0]   wdata;

    modport source (output valid, reg_index, wdata, input ready);
    modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// File: rtl/core/rtc_fields_to_epoch_seconds.sv
// Channel   Direction  Payload                                        Handshake
// i_snap    in         century/year/month/day/hour/minute/second_raw  valid/ready
// o_epoch   out        epoch_seconds, invalid                         valid/ready
// i_cfg     in         reg_index, wdata                               valid/ready
//
// Six register stages, 0 to 5. An accepted snapshot transaction passes through every
// stage in order, and o_epoch.valid is the valid bit of stage 5. One snapshot per
// cycle is accepted while i_snap.ready is high; the stage depth is set by the
// divide-by-100 multiply and the day-count adder that follow the decode.
// Reset clears every stage valid bit and sets both mode registers to 1.
// A stalled stage holds; each stage moves on when it is empty or its successor moves,
// so bubbles are squeezed out and i_snap.ready falls only when every stage is full.
module rtc_fields_to_epoch_seconds #(
    parameter int unsigned EPOCH_YEAR = rfe_pkg::EPOCH_YEAR
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rfe_in_if.sink     i_snap,
    rfe_cfg_if.sink    i_cfg,
    rfe_out_if.source  o_epoch
);

    localparam int unsigned YW = rfe_pkg::YEAR_W;
    localparam int unsigned DW = rfe_pkg::DAYS_W;
    localparam int unsigned TW = rfe_pkg::TOD_W;
    localparam int unsigned QW = rfe_pkg::Q_W;
    localparam int unsigned RW = rfe_pkg::RAW_W;
    localparam int unsigned MW = rfe_pkg::MONTH_W;
    localparam int unsigned BW = rfe_pkg::BEFORE_W;
    localparam int unsigned EW = rfe_pkg::EPOCH_W;
    localparam int unsigned PW = YW + rfe_pkg::RECIP_W;

    // Days from 1 January of year 1 to 1 January of the epoch year.
    localparam logic [DW-1:0] EPOCH_DAYS = DW'(rfe_pkg::year_start_days(EPOCH_YEAR));

    // Mode registers. Writes are only expected while the pipeline is empty,
    // so stage 0 can read them directly.
    logic r_bcd_mode;
    logic r_hour_24_mode;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcd_mode     <= 1'b1;
            r_hour_24_mode <= 1'b1;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.reg_index)
                rfe_pkg::REG_BCD_MODE:     r_bcd_mode     <= i_cfg.wdata[0];
                rfe_pkg::REG_HOUR_24_MODE: r_hour_24_mode <= i_cfg.wdata[0];
                default: ;
            endcase
        end
    end

    // Stage valid bits and per-stage advance enables. A stage loads when it
    // is empty or when the stage after it is loading.
    logic r_v0, r_v1, r_v2, r_v3, r_v4, r_v5;
    logic en0, en1, en2, en3, en4, en5;

    assign en5 = !r_v5 || o_epoch.ready;
    assign en4 = !r_v4 || en5;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign en0 = !r_v0 || en1;

    assign i_snap.ready = en0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en0) r_v0 <= i_snap.valid;
            if (en1) r_v1 <= r_v0;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
        end
    end

    // Stage 0: decode the bytes, map the hour to 24-hour form, check the date.
    logic [RW-1:0] n0_century, n0_year, n0_month, n0_day;
    logic [RW-1:0] n0_hour, n0_minute, n0_second, n0_h12;
    logic          n0_inv;

    always_comb begin
        n0_century = rfe_pkg::decode_byte(i_snap.century_raw, r_bcd_mode);
        n0_year    = rfe_pkg::decode_byte(i_snap.year_raw, r_bcd_mode);
        n0_month   = rfe_pkg::decode_byte(i_snap.month_raw, r_bcd_mode);
        n0_day     = rfe_pkg::decode_byte(i_snap.day_raw, r_bcd_mode);
        n0_minute  = rfe_pkg::decode_byte(i_snap.minute_raw, r_bcd_mode);
        n0_second  = rfe_pkg::decode_byte(i_snap.second_raw, r_bcd_mode);
        n0_h12     = rfe_pkg::decode_byte(i_snap.hour_raw & rfe_pkg::HOUR_MASK,
                                          r_bcd_mode);
        // In 12-hour form, twelve o'clock is midnight without the PM bit and
        // noon with it; other PM hours move up by twelve.
        if (r_hour_24_mode) begin
            n0_hour = rfe_pkg::decode_byte(i_snap.hour_raw, r_bcd_mode);
        end else if (i_snap.hour_raw[rfe_pkg::HOUR_PM_BIT]) begin
            n0_hour = (n0_h12 == rfe_pkg::NOON_HOUR) ? n0_h12
                                                      : RW'(n0_h12 + rfe_pkg::NOON_HOUR);
        end else begin
            n0_hour = (n0_h12 == rfe_pkg::NOON_HOUR) ? RW'(0) : n0_h12;
        end
        n0_inv = (n0_month == RW'(0)) || (n0_month > RW'(12)) || (n0_day == RW'(0));
    end

    logic [RW-1:0] r0_century, r0_year, r0_day, r0_hour, r0_minute, r0_second;
    logic [MW-1:0] r0_month;
    logic          r0_inv;

    always_ff @(posedge i_clk) begin
        if (en0) begin
            r0_century <= n0_century;
            r0_year    <= n0_year;
            r0_month   <= n0_month[MW-1:0];
            r0_day     <= n0_day;
            r0_hour    <= n0_hour;
            r0_minute  <= n0_minute;
            r0_second  <= n0_second;
            r0_inv     <= n0_inv;
        end
    end

    // Stage 1: full year and the time of day in seconds.
    logic [YW-1:0] r1_year;
    logic [TW-1:0] r1_tod;
    logic [MW-1:0] r1_month;
    logic [RW-1:0] r1_day;
    logic          r1_inv;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_year  <= YW'(r0_century) * YW'(100) + YW'(r0_year);
            r1_tod   <= TW'(r0_hour) * TW'(3600) + TW'(r0_minute) * TW'(60)
                        + TW'(r0_second);
            r1_month <= r0_month;
            r1_day   <= r0_day;
            r1_inv   <= r0_inv;
        end
    end

    // Stage 2: century count by multiplying with the reciprocal of 100.
    logic [PW-1:0] n2_prod;
    assign n2_prod = PW'(r1_year) * PW'(rfe_pkg::RECIP_100);

    logic [YW-1:0] r2_year;
    logic [QW-1:0] r2_q;
    logic [TW-1:0] r2_tod;
    logic [MW-1:0] r2_month;
    logic [RW-1:0] r2_day;
    logic          r2_inv;

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_year  <= r1_year;
            r2_q     <= QW'(n2_prod >> rfe_pkg::RECIP_SHIFT);
            r2_tod   <= r1_tod;
            r2_month <= r1_month;
            r2_day   <= r1_day;
            r2_inv   <= r1_inv;
        end
    end

    // Stage 3: leap test and days before 1 January of the full year.
    // For p = year - 1, p / 100 is one less than year / 100 when the year is
    // a whole century. Year zero gives p = -1 and truncated quotients of
    // zero, so its count is simply minus 365.
    logic          n3_cent, n3_leap, n3_zero;
    logic [YW-1:0] n3_p;
    logic [QW-1:0] n3_p100;
    logic [DW-1:0] n3_base;
    logic [BW-1:0] n3_before;

    always_comb begin
        n3_zero = (r2_year == YW'(0));
        n3_cent = (r2_year == YW'(r2_q * YW'(100)));
        n3_leap = ((r2_year[1:0] == 2'd0) && !n3_cent)
                  || (n3_cent && (r2_q[1:0] == 2'd0));
        n3_p    = r2_year - YW'(1);
        n3_p100 = n3_cent ? QW'(r2_q - QW'(1)) : r2_q;
        n3_base = n3_zero ? DW'(-365)
                          : DW'(n3_p) * DW'(365) + DW'(n3_p >> 2)
                            - DW'(n3_p100) + DW'(n3_p100 >> 2);
        n3_before = rfe_pkg::cum_days(r2_month)
                    + BW'((r2_month > MW'(2)) && n3_leap);
    end

    logic [DW-1:0] r3_base;
    logic [BW-1:0] r3_before;
    logic [RW-1:0] r3_day;
    logic [TW-1:0] r3_tod;
    logic [YW-1:0] r3_year;
    logic          r3_leap;
    logic          r3_inv;

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_base   <= n3_base;
            r3_before <= n3_before;
            r3_day    <= r2_day;
            r3_tod    <= r2_tod;
            r3_year   <= r2_year;
            r3_leap   <= n3_leap;
            r3_inv    <= r2_inv;
        end
    end

    // Stage 4: signed day difference to the epoch.
    logic [DW-1:0] r4_days;
    logic [TW-1:0] r4_tod;
    logic          r4_inv;

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_days <= r3_base + DW'(r3_before) + DW'(r3_day) - DW'(1)
                       - EPOCH_DAYS;
            r4_tod  <= r3_tod;
            r4_inv  <= r3_inv;
        end
    end

    // Stage 5: seconds, wrapping modulo 2**32; an invalid date reads as zero.
    logic [EW-1:0] n5_days;
    logic [EW-1:0] n5_secs;

    assign n5_days = {{(EW - DW){r4_days[DW-1]}}, r4_days};
    assign n5_secs = n5_days * EW'(86400) + EW'(r4_tod);

    logic [EW-1:0] r5_secs;
    logic          r5_inv;

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r5_secs <= r4_inv ? EW'(0) : n5_secs;
            r5_inv  <= r4_inv;
        end
    end

    assign o_epoch.valid         = r_v5;
    assign o_epoch.epoch_seconds = r5_secs;
    assign o_epoch.invalid       = r5_inv;

`ifndef SYNTHESIS
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v5 && r5_inv |-> r5_secs == EW'(0))
        else $error("invalid result carries nonzero seconds");

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_snap.valid && i_snap.ready |=> r_v0)
        else $error("accepted snapshot missing from first stage");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v0 |-> i_snap.ready)
        else $error("empty first stage refuses a snapshot");

    a_leap_div4: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && (r3_year[1:0] != 2'd0) |-> !r3_leap)
        else $error("leap flag set for a year not divisible by four");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 && !en4 |=> r_v4 && $stable(r4_days))
        else $error("stalled stage lost its day count");
`endif

endmodule
